// ===== rtl/clt_pkg.sv =====
// Shared types and constants for the command line tokenizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package clt_pkg;

  localparam int unsigned MaxTokenLen = 255;
  localparam int unsigned MaxArgs     = 80;
  localparam int unsigned ArgW        = 7;
  localparam int unsigned TokLenW     = $clog2(MaxTokenLen + 1);
  localparam int unsigned MaxRes      = 4;
  localparam int unsigned ResIdxW     = $clog2(MaxRes);
  localparam int unsigned ResCntW     = $clog2(MaxRes + 1);
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QPtrW       = $clog2(QueueDepth);

  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharLf     = 8'h0a;
  localparam logic [7:0] CharCr     = 8'h0d;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharDquote = 8'h22;
  localparam logic [7:0] CharSquote = 8'h27;
  localparam logic [7:0] CharLparen = 8'h28;
  localparam logic [7:0] CharRparen = 8'h29;
  localparam logic [7:0] CharComma  = 8'h2c;
  localparam logic [7:0] CharSlash  = 8'h2f;
  localparam logic [7:0] CharBslash = 8'h5c;
  localparam logic [7:0] CharLbrace = 8'h7b;
  localparam logic [7:0] CharRbrace = 8'h7d;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_CMD_END   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    LM_DONE        = 3'd0,
    LM_TOP         = 3'd1,
    LM_POSTCOMMENT = 3'd2,
    LM_SLASH       = 3'd3,
    LM_COMMENT     = 3'd4,
    LM_WORD        = 3'd5,
    LM_QUOTE       = 3'd6,
    LM_QUOTE_BS    = 3'd7
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       start_text;
  } in_word_t;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      out_char;
    logic [ArgW-1:0] arg_index;
    logic            truncated;
    logic            last;
  } out_word_t;

  // All results caused by one input word.
  typedef struct packed {
    out_word_t [MaxRes-1:0] res;
    logic [ResCntW-1:0]     cnt;
  } burst_t;

endpackage

`default_nettype wire

// ===== rtl/clt_lexer.sv =====
// Lexer state machine: consumes one character per accepted word and
// produces the burst of results it causes. Depends on clt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clt_lexer (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_fire_i,
  input  wire clt_pkg::in_word_t        in_data_i,
  input  wire logic [clt_pkg::ArgW-1:0] max_args_i,
  output clt_pkg::burst_t               burst_o
);
  import clt_pkg::*;

  typedef struct packed {
    lex_mode_e          mode;
    logic [ArgW-1:0]    cnt;
    logic [TokLenW-1:0] len;
    logic               ovf;
    logic               kept;
    burst_t             out;
  } ctx_t;

  lex_mode_e          mode_q;
  logic [ArgW-1:0]    arg_cnt_q;
  logic [TokLenW-1:0] tok_len_q;
  logic               ovf_q;
  logic               kept_q;

  ctx_t               ctx;
  logic               again;
  logic [ArgW-1:0]    lim;
  logic [ResCntW-1:0] last_pos;
  logic [7:0]         ch;

  function automatic logic is_punct(logic [7:0] c);
    return c == CharLbrace || c == CharRbrace || c == CharRparen ||
           c == CharLparen || c == CharSquote || c == CharComma;
  endfunction

  function automatic ctx_t emit(ctx_t c, kind_e k, logic [7:0] b, logic tr);
    ctx_t r;
    r = c;
    if (c.out.cnt < ResCntW'(MaxRes)) begin
      r.out.res[c.out.cnt[ResIdxW-1:0]] =
        '{kind: k, out_char: b, arg_index: c.cnt, truncated: tr, last: 1'b0};
      r.out.cnt = c.out.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic ctx_t begin_tok(ctx_t c, logic [ArgW-1:0] l);
    ctx_t r;
    r = c;
    r.len  = '0;
    r.ovf  = 1'b0;
    r.kept = c.cnt < l;
    return r;
  endfunction

  function automatic ctx_t push(ctx_t c, logic [7:0] b);
    ctx_t r;
    r = c;
    if (c.kept) begin
      if (c.len < TokLenW'(MaxTokenLen)) begin
        r = emit(c, KIND_BYTE, b, 1'b0);
        r.len = c.len + 1'b1;
      end else begin
        r.ovf = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic ctx_t end_tok(ctx_t c);
    ctx_t r;
    r = c;
    if (c.kept) begin
      r = emit(c, KIND_TOKEN_END, CharNul, c.ovf);
      r.cnt = c.cnt + 1'b1;
    end
    r.kept = 1'b0;
    return r;
  endfunction

  function automatic ctx_t end_cmd(ctx_t c);
    ctx_t r;
    r = emit(c, KIND_CMD_END, CharNul, 1'b0);
    r.mode = LM_DONE;
    return r;
  endfunction

  function automatic ctx_t tok_start(ctx_t c, logic [7:0] b, logic [ArgW-1:0] l);
    ctx_t r;
    r = c;
    if (b == CharSlash) begin
      r.mode = LM_SLASH;
    end else if (b == CharDquote) begin
      r = begin_tok(c, l);
      r.mode = LM_QUOTE;
    end else if (is_punct(b)) begin
      r = end_tok(push(begin_tok(c, l), b));
      r.mode = LM_TOP;
    end else begin
      r = push(begin_tok(c, l), b);
      r.mode = LM_WORD;
    end
    return r;
  endfunction

  assign lim = (max_args_i < ArgW'(MaxArgs)) ? max_args_i : ArgW'(MaxArgs);
  assign ch  = in_data_i.char_code;

  always_comb begin
    ctx.mode = mode_q;
    ctx.cnt  = arg_cnt_q;
    ctx.len  = tok_len_q;
    ctx.ovf  = ovf_q;
    ctx.kept = kept_q;
    ctx.out  = '0;
    if (in_data_i.start_text) begin
      ctx.mode = LM_TOP;
      ctx.cnt  = '0;
      ctx.len  = '0;
      ctx.ovf  = 1'b0;
      ctx.kept = 1'b0;
    end
    // at most three passes: slash -> word -> top
    again = 1'b1;
    for (int p = 0; p < 3; p++) begin
      if (again) begin
        again = 1'b0;
        unique case (ctx.mode)
          LM_DONE: begin
          end
          LM_TOP: begin
            if (ch == CharNul || ch == CharLf || ch == CharCr) begin
              ctx = end_cmd(ctx);
            end else if (ch > CharSpace) begin
              ctx = tok_start(ctx, ch, lim);
            end
          end
          LM_POSTCOMMENT: begin
            if (ch == CharNul) begin
              ctx = end_cmd(ctx);
            end else if (ch > CharSpace) begin
              ctx = tok_start(ctx, ch, lim);
            end
          end
          LM_SLASH: begin
            if (ch == CharSlash) begin
              ctx.mode = LM_COMMENT;
            end else begin
              ctx = push(begin_tok(ctx, lim), CharSlash);
              ctx.mode = LM_WORD;
              again = 1'b1;
            end
          end
          LM_COMMENT: begin
            if (ch == CharNul) begin
              ctx = end_cmd(ctx);
            end else if (ch == CharLf) begin
              ctx.mode = LM_POSTCOMMENT;
            end
          end
          LM_WORD: begin
            if (ch <= CharSpace || is_punct(ch)) begin
              ctx = end_tok(ctx);
              ctx.mode = LM_TOP;
              again = 1'b1;
            end else begin
              ctx = push(ctx, ch);
            end
          end
          LM_QUOTE: begin
            if (ch == CharNul) begin
              ctx = end_cmd(end_tok(ctx));
            end else if (ch == CharBslash) begin
              ctx.mode = LM_QUOTE_BS;
            end else if (ch == CharDquote) begin
              ctx = end_tok(ctx);
              ctx.mode = LM_TOP;
            end else begin
              ctx = push(ctx, ch);
            end
          end
          LM_QUOTE_BS: begin
            ctx.mode = LM_QUOTE;
            if (ch == CharDquote) begin
              ctx = push(ctx, CharDquote);
            end else begin
              ctx = push(ctx, CharBslash);
              again = 1'b1;
            end
          end
        endcase
      end
    end
    last_pos = ctx.out.cnt - 1'b1;
    if (ctx.out.cnt != '0) begin
      ctx.out.res[last_pos[ResIdxW-1:0]].last = 1'b1;
    end
  end

  assign burst_o = ctx.out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= LM_DONE;
      arg_cnt_q <= '0;
      tok_len_q <= '0;
      ovf_q     <= 1'b0;
      kept_q    <= 1'b0;
    end else if (in_fire_i) begin
      mode_q    <= ctx.mode;
      arg_cnt_q <= ctx.cnt;
      tok_len_q <= ctx.len;
      ovf_q     <= ctx.ovf;
      kept_q    <= ctx.kept;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clt_res_queue.sv =====
// Result queue: holds bursts from the lexer and hands out one result word
// per cycle while out_ready_i is high. Depends on clt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clt_res_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire clt_pkg::burst_t burst_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output clt_pkg::out_word_t   out_data_o
);
  import clt_pkg::*;

  burst_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q;
  logic [QPtrW-1:0]   rd_ptr_q;
  logic [QPtrW:0]     count_q;
  logic [ResIdxW-1:0] sub_q;

  burst_t             head;
  logic [ResCntW-1:0] head_last;
  logic               pop;
  logic               entry_done;

  assign head        = mem_q[rd_ptr_q];
  assign head_last   = head.cnt - 1'b1;
  assign out_valid_o = count_q != '0;
  assign out_data_o  = head.res[sub_q];
  assign full_o      = count_q == (QPtrW + 1)'(QueueDepth);
  assign pop         = out_valid_o && out_ready_i;
  assign entry_done  = pop && (sub_q == head_last[ResIdxW-1:0]);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= burst_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      sub_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (entry_done) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
        sub_q    <= '0;
      end else if (pop) begin
        sub_q <= sub_q + 1'b1;
      end
      if (push_i && !entry_done) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && entry_done) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/command_line_tokenizer_unit.sv =====
// Command line tokenizer top level: max_args register, lexer, result queue.
// Depends on clt_pkg, clt_lexer and clt_res_queue.
// A character's burst enters the result queue when the character is taken.
// Throughput: one character per cycle; a character yields up to four results,
// which leave the four-burst result queue at one per cycle while out_ready_i
// is high. Input stalls only while that queue is full.
// Reset: lexer waits for a start word, counters clear, max_args returns to 80.
`timescale 1ns / 1ps
`default_nettype none

module command_line_tokenizer_unit (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire clt_pkg::in_word_t        in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output clt_pkg::out_word_t            out_data_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [clt_pkg::ArgW-1:0] cfg_data_i
);
  import clt_pkg::*;

  logic [ArgW-1:0] max_args_q;
  logic            in_fire;
  logic            full;
  burst_t          burst;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_args_q <= ArgW'(MaxArgs);
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_args_q <= cfg_data_i;
    end
  end

  clt_lexer u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_data_i  (in_data_i),
    .max_args_i (max_args_q),
    .burst_o    (burst)
  );

  clt_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire && (burst.cnt != '0)),
    .burst_i     (burst),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_trunc_only_on_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_TOKEN_END |-> !out_data_o.truncated)
    else $error("truncated flag on a result that is not an end of token");

  a_char_only_on_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_BYTE |-> out_data_o.out_char == '0)
    else $error("nonzero character on a non-byte result");

  a_cmd_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_CMD_END |-> out_data_o.last)
    else $error("end of command not marked last");

  a_full_has_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with an empty result queue");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for command_line_tokenizer_unit: directed and random command texts,
// checked word by word against a tokenizer predictor kept in this file.
// Depends on clt_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
  import clt_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_word_t   in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_word_t  out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [6:0] cfg_data_i;

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned mismatch_count;

  // tokenizer predictor state
  logic [6:0]  arg_limit_reg;
  lex_mode_e   lex_mode;
  logic [6:0]  arg_count;
  int unsigned tok_len;
  logic        tok_ovf;
  logic        tok_kept;
  out_word_t   burst_q[$];
  out_word_t   pending_words[$];

  command_line_tokenizer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= sink_stall_pct);
  end

  function automatic logic is_punct(logic [7:0] c);
    return c == CharLbrace || c == CharRbrace || c == CharLparen || c == CharRparen ||
           c == CharSquote || c == CharComma;
  endfunction

  function automatic logic [6:0] eff_limit();
    return (arg_limit_reg < MaxArgs) ? arg_limit_reg : 7'(MaxArgs);
  endfunction

  task automatic put_result(kind_e k, logic [7:0] ch, logic tr);
    out_word_t w;
    w.kind      = k;
    w.out_char  = ch;
    w.arg_index = arg_count;
    w.truncated = tr;
    w.last      = 1'b0;
    if (burst_q.size() < MaxRes) burst_q.push_back(w);
  endtask

  task automatic start_token();
    tok_len  = 0;
    tok_ovf  = 1'b0;
    tok_kept = arg_count < eff_limit();
  endtask

  task automatic keep_char(logic [7:0] c);
    if (tok_kept) begin
      if (tok_len < MaxTokenLen) begin
        put_result(KIND_BYTE, c, 1'b0);
        tok_len++;
      end else begin
        tok_ovf = 1'b1;
      end
    end
  endtask

  task automatic close_token();
    if (tok_kept) begin
      put_result(KIND_TOKEN_END, 8'h00, tok_ovf);
      arg_count = arg_count + 7'd1;
    end
    tok_kept = 1'b0;
  endtask

  task automatic close_command();
    put_result(KIND_CMD_END, 8'h00, 1'b0);
    lex_mode = LM_DONE;
  endtask

  task automatic open_token(logic [7:0] c);
    if (c == CharSlash) begin
      lex_mode = LM_SLASH;
    end else if (c == CharDquote) begin
      start_token();
      lex_mode = LM_QUOTE;
    end else if (is_punct(c)) begin
      start_token();
      keep_char(c);
      close_token();
      lex_mode = LM_TOP;
    end else begin
      start_token();
      keep_char(c);
      lex_mode = LM_WORD;
    end
  endtask

  task automatic tokenize_char(logic [7:0] c, logic s);
    logic      again;
    out_word_t w;
    burst_q.delete();
    if (s) begin
      lex_mode  = LM_TOP;
      arg_count = '0;
      tok_len   = 0;
      tok_ovf   = 1'b0;
      tok_kept  = 1'b0;
    end
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (lex_mode)
        LM_TOP: begin
          if (c == CharNul || c == CharLf || c == CharCr) close_command();
          else if (c > CharSpace) open_token(c);
        end
        LM_POSTCOMMENT: begin
          if (c == CharNul) close_command();
          else if (c > CharSpace) open_token(c);
        end
        LM_SLASH: begin
          if (c == CharSlash) begin
            lex_mode = LM_COMMENT;
          end else begin
            start_token();
            keep_char(CharSlash);
            lex_mode = LM_WORD;
            again = 1'b1;
          end
        end
        LM_COMMENT: begin
          if (c == CharNul) close_command();
          else if (c == CharLf) lex_mode = LM_POSTCOMMENT;
        end
        LM_WORD: begin
          if (c <= CharSpace || is_punct(c)) begin
            close_token();
            lex_mode = LM_TOP;
            again = 1'b1;
          end else begin
            keep_char(c);
          end
        end
        LM_QUOTE: begin
          if (c == CharNul) begin
            close_token();
            close_command();
          end else if (c == CharBslash) begin
            lex_mode = LM_QUOTE_BS;
          end else if (c == CharDquote) begin
            close_token();
            lex_mode = LM_TOP;
          end else begin
            keep_char(c);
          end
        end
        LM_QUOTE_BS: begin
          lex_mode = LM_QUOTE;
          if (c == CharDquote) begin
            keep_char(CharDquote);
          end else begin
            keep_char(CharBslash);
            again = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (burst_q.size() > 0) begin
      w = burst_q.pop_back();
      w.last = 1'b1;
      burst_q.push_back(w);
    end
    foreach (burst_q[i]) pending_words.push_back(burst_q[i]);
  endtask

  always @(posedge clk_i) begin : scoreboard
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected word: kind=%0d char=%02h idx=%0d trunc=%b last=%b",
                     out_data_o.kind, out_data_o.out_char, out_data_o.arg_index,
                     out_data_o.truncated, out_data_o.last);
        end else begin
          want = pending_words.pop_front();
          if (out_data_o.kind !== want.kind || out_data_o.out_char !== want.out_char ||
              out_data_o.arg_index !== want.arg_index ||
              out_data_o.truncated !== want.truncated || out_data_o.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: got kind=%0d char=%02h idx=%0d trunc=%b last=%b, exp kind=%0d char=%02h idx=%0d trunc=%b last=%b",
                       out_data_o.kind, out_data_o.out_char, out_data_o.arg_index,
                       out_data_o.truncated, out_data_o.last,
                       want.kind, want.out_char, want.arg_index, want.truncated, want.last);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) arg_limit_reg = cfg_data_i;
      if (in_valid_i && in_ready_o) tokenize_char(in_data_i.char_code, in_data_i.start_text);
    end
  end

  task automatic send_char(logic [7:0] c, logic s);
    while ($urandom_range(0, 99) < src_idle_pct) @(negedge clk_i);
    in_data_i.char_code  = c;
    in_data_i.start_text = s;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_text(string t, logic first_start);
    for (int i = 0; i < t.len(); i++) send_char(t[i], first_start && i == 0);
  endtask

  task automatic drain_results();
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_max_args(logic [6:0] v);
    drain_results();
    cfg_data_i  = v;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // word, punctuation, escaped and literal backslash in quotes, comment, 0xff byte
  task automatic test_syntax();
    send_text("a{\"x\\\"\\q\"//", 1'b1);
    send_char(CharLf, 1'b0);
    send_char(CharSpace, 1'b0);
    send_char("b", 1'b0);
    send_char(8'hff, 1'b0);
    send_char(CharNul, 1'b0);
    send_char("z", 1'b0);
  endtask

  task automatic test_restart_and_slash();
    send_text("wo", 1'b1);
    send_char(CharSlash, 1'b1);
    send_char(CharNul, 1'b0);
    send_text("//x", 1'b1);
    send_char(CharNul, 1'b0);
  endtask

  task automatic test_punct_and_empty_quote();
    send_text("\"\"()',}", 1'b1);
    send_char(CharCr, 1'b0);
  endtask

  task automatic test_arg_limits();
    write_max_args(7'd0);
    send_text("ab c", 1'b1);
    send_char(CharNul, 1'b0);
    write_max_args(7'd1);
    send_text("ab c", 1'b1);
    send_char(CharNul, 1'b0);
    write_max_args(7'd127);
    send_text("{ab( c", 1'b1);
    send_char(CharCr, 1'b0);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 255));
    while (is_punct(c) || c == CharDquote || c == CharSlash);
    return c;
  endfunction

  task automatic random_command(output int n_sent);
    logic [7:0] text_q[$];
    int         n_tok;
    int         len;
    int         n_junk;
    n_sent = 0;
    if ($urandom_range(0, 4) == 0) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) send_char(8'($urandom_range(0, 255)), 1'($urandom));
      n_sent = len;
      return;
    end
    n_tok = $urandom_range(1, 5);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(0, 4))
        0: begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) text_q.push_back(word_char());
        end
        1: begin
          text_q.push_back(CharDquote);
          len = $urandom_range(0, 5);
          for (int i = 0; i < len; i++)
            text_q.push_back(($urandom_range(0, 3) == 0) ? CharBslash :
                             8'($urandom_range(1, 255)));
          if ($urandom_range(0, 3) != 0) text_q.push_back(CharDquote);
        end
        2: begin
          case ($urandom_range(0, 5))
            0: text_q.push_back(CharLbrace);
            1: text_q.push_back(CharRbrace);
            2: text_q.push_back(CharLparen);
            3: text_q.push_back(CharRparen);
            4: text_q.push_back(CharSquote);
            default: text_q.push_back(CharComma);
          endcase
        end
        3: begin
          text_q.push_back(CharSlash);
          len = $urandom_range(0, 3);
          for (int i = 0; i < len; i++) text_q.push_back(word_char());
        end
        default: begin
          text_q.push_back(CharSlash);
          text_q.push_back(CharSlash);
          len = $urandom_range(0, 4);
          for (int i = 0; i < len; i++) text_q.push_back(8'($urandom_range(32, 126)));
          text_q.push_back(CharLf);
        end
      endcase
      text_q.push_back(($urandom_range(0, 3) == 0) ? 8'h09 : CharSpace);
    end
    case ($urandom_range(0, 3))
      0: text_q.push_back(CharNul);
      1: text_q.push_back(CharLf);
      2: text_q.push_back(CharCr);
      default: ;
    endcase
    foreach (text_q[i]) send_char(text_q[i], i == 0);
    n_sent = text_q.size();
    n_junk = $urandom_range(0, 2);
    for (int i = 0; i < n_junk; i++) send_char(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic test_random_traffic();
    int         sent;
    int         n;
    logic [6:0] lim;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: lim = 7'd80;
        1: lim = 7'd1;
        2: lim = 7'($urandom_range(2, 6));
        default: lim = 7'd127;
      endcase
      write_max_args(lim);
      case (p)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 63; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 63; end
        default: begin src_idle_pct = 23; sink_stall_pct = 23; end
      endcase
      sent = 0;
      while (sent < 16) begin
        random_command(n);
        sent += n;
        if ($urandom_range(0, 9) == 0) drain_results();
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    mismatch_count = 0;
    arg_limit_reg  = 7'(MaxArgs);
    lex_mode       = LM_DONE;
    arg_count      = '0;
    tok_len        = 0;
    tok_ovf        = 1'b0;
    tok_kept       = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_syntax();
    test_restart_and_slash();
    test_punct_and_empty_quote();
    test_arg_limits();
    test_random_traffic();

    drain_results();
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
